// ----- rtl/argsp_pkg.sv -----
// shared types, character codes and scanner states for the macro argument splitter
// no dependencies; imported by the front, queue, back, core and testbench
package argsp_pkg;

    // default ceiling of the parenthesis depth counter
    localparam int MAX_DEPTH_DEF = 255;

    // entries in the queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // end kind codes
    localparam logic END_COMMA = 1'b0;
    localparam logic END_RPAR  = 1'b1;

    // scanner states
    typedef enum logic [3:0] {
        ST_NORMAL     = 4'd0,
        ST_SLASH      = 4'd1,
        ST_BLOCK      = 4'd2,
        ST_BLOCK_STAR = 4'd3,
        ST_LINE       = 4'd4,
        ST_STR        = 4'd5,
        ST_STR_ESC    = 4'd6,
        ST_CHR        = 4'd7,
        ST_CHR_ESC    = 4'd8
    } scan_state_t;

    // one result item without its last flag
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       arg_end;
        logic       end_kind;
    } result_t;

    // one classified input: one or two results
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } q_entry_t;

    // queue head as seen by the back part
    typedef struct packed {
        logic     avail;
        q_entry_t entry;
    } q_head_t;

    // result carrying a character
    function automatic result_t mk_byte(input logic [7:0] b);
        result_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.arg_end    = 1'b0;
        r.end_kind   = 1'b0;
        return r;
    endfunction

    // result marking the end of the argument
    function automatic result_t mk_end(input logic kind);
        result_t r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.arg_end    = 1'b1;
        r.end_kind   = kind;
        return r;
    endfunction

endpackage

// ----- rtl/argsp_if.sv -----
// valid/ready channel interfaces for the macro argument splitter
// depends on nothing; the input and result channels live here
interface argsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       mode;

    modport source (output valid, output in_byte, output mode, input ready);
    modport sink   (input valid, input in_byte, input mode, output ready);
endinterface

interface argsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       arg_end;
    logic       end_kind;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output arg_end,
                    output end_kind, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input arg_end,
                    input end_kind, input last, output ready);
endinterface

// ----- rtl/macro_argument_splitter_core.sv -----
// top level of the macro argument splitter: front scanner, queue, result back end
// depends on argsp_pkg, argsp_if, argsp_front, argsp_queue, argsp_back
//
// Passes the bytes of one C macro argument through while tracking parenthesis
// depth, string and character literals and comments; a comma or closing
// parenthesis at depth zero outside them is reported as an argument end
// instead of echoed, and the scanner returns to its reset state. The front
// scanner takes one input item per cycle as long as the two-entry queue has
// room; the back end sends one result item per cycle while the result side is
// ready, so an input that gives two results (a held comment backslash followed
// by a byte other than a newline or backslash) yields two result items, and an
// input that gives none adds nothing to the queue. No clearing pass after reset.
module macro_argument_splitter_core
    import argsp_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    argsp_in_if.sink    in_ch,
    argsp_out_if.source out_ch
);

    logic     q_ready;
    logic     push;
    q_entry_t push_entry;
    logic     pop;
    q_head_t  head;

    // scanner
    argsp_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_byte    (in_ch.in_byte),
        .mode       (in_ch.mode),
        .in_ready   (in_ch.ready),
        .q_ready    (q_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue between front and back
    argsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .head       (head)
    );

    // result sequencer
    argsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_byte   (out_ch.out_byte),
        .byte_valid (out_ch.byte_valid),
        .arg_end    (out_ch.arg_end),
        .end_kind   (out_ch.end_kind),
        .last       (out_ch.last)
    );

    // an entry leaves the queue only with its final result
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> out_ch.valid && out_ch.ready && out_ch.last)
        else $error("queue popped before final result");

    // argument end results carry no character and close their input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.arg_end |-> !out_ch.byte_valid && out_ch.last)
        else $error("malformed argument end result");

    // input stalls only when the queue holds entries
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> head.avail)
        else $error("input stalled with empty queue");

endmodule

// ----- rtl/argsp_front.sv -----
// front part: scanner state machine, classifies each input into queue entries
// depends on argsp_pkg
module argsp_front
    import argsp_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       mode,
    output logic       in_ready,
    input  logic       q_ready,
    output logic       push,
    output q_entry_t   push_entry
);

    localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH + 1) : 1;
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    scan_state_t   state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          pb_reg, pb_next;

    scan_state_t   scan_state;
    logic [DW-1:0] scan_depth;
    logic          scan_pb;
    logic          scan_has;
    logic          do_code;
    result_t       scan_res;
    logic          has_any;
    logic          accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_NORMAL;
            depth_reg <= '0;
            pb_reg    <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            pb_reg    <= pb_next;
        end
    end

    // per-state scan of one byte
    always_comb
    begin
        scan_state = state_reg;
        scan_depth = depth_reg;
        scan_pb    = 1'b0;
        scan_has   = 1'b1;
        scan_res   = mk_byte(in_byte);
        do_code    = 1'b0;

        unique case (state_reg)
            ST_NORMAL:
                do_code = 1'b1;
            ST_SLASH:
            begin
                if (in_byte == CH_STAR)
                    scan_state = ST_BLOCK;
                else if (in_byte == CH_SLASH)
                    scan_state = ST_LINE;
                else
                    do_code = 1'b1;
            end
            ST_BLOCK:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    scan_pb  = 1'b1;
                    scan_has = 1'b0;
                end
                else if (in_byte == CH_STAR)
                    scan_state = ST_BLOCK_STAR;
            end
            ST_BLOCK_STAR:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    scan_state = ST_BLOCK;
                    scan_pb    = 1'b1;
                    scan_has   = 1'b0;
                end
                else if (in_byte == CH_SLASH)
                    scan_state = ST_NORMAL;
                else if (in_byte != CH_STAR)
                    scan_state = ST_BLOCK;
            end
            ST_LINE:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    scan_pb  = 1'b1;
                    scan_has = 1'b0;
                end
                else if (in_byte == CH_NL)
                    scan_state = ST_NORMAL;
            end
            ST_STR:
            begin
                if (in_byte == CH_DQUOTE)
                    scan_state = ST_NORMAL;
                else if (in_byte == CH_BSLASH)
                    scan_state = ST_STR_ESC;
            end
            ST_STR_ESC:
                scan_state = ST_STR;
            ST_CHR:
            begin
                if (in_byte == CH_NL || in_byte == CH_SQUOTE)
                    scan_state = ST_NORMAL;
                else if (in_byte == CH_BSLASH)
                    scan_state = ST_CHR_ESC;
            end
            ST_CHR_ESC:
                scan_state = ST_CHR;
            default:
                do_code = 1'b1;
        endcase

        // ordinary code byte
        if (do_code)
        begin
            scan_state = ST_NORMAL;
            if (depth_reg == '0 && (in_byte == CH_RPAR || in_byte == CH_COMMA))
            begin
                scan_res   = mk_end((in_byte == CH_RPAR) ? END_RPAR : END_COMMA);
                scan_depth = '0;
            end
            else if (in_byte == CH_LPAR)
            begin
                if (depth_reg < DEPTH_MAX)
                    scan_depth = depth_reg + 1'b1;
            end
            else if (in_byte == CH_RPAR)
                scan_depth = depth_reg - 1'b1;
            else if (in_byte == CH_DQUOTE)
                scan_state = ST_STR;
            else if (in_byte == CH_SQUOTE)
                scan_state = ST_CHR;
            else if (in_byte == CH_SLASH)
                scan_state = ST_SLASH;
        end
    end

    // pending backslash and flush handling, queue entry build
    always_comb
    begin
        state_next    = scan_state;
        depth_next    = scan_depth;
        pb_next       = scan_pb;
        push_entry.two = 1'b0;
        push_entry.r0  = scan_res;
        push_entry.r1  = scan_res;
        has_any        = scan_has;

        priority if (mode)
        begin
            state_next    = ST_NORMAL;
            depth_next    = '0;
            pb_next       = 1'b0;
            push_entry.r0 = mk_byte(CH_BSLASH);
            has_any       = pb_reg;
        end
        else if (pb_reg && in_byte == CH_NL)
        begin
            // backslash-newline in a comment folds to one space
            state_next    = state_reg;
            depth_next    = depth_reg;
            pb_next       = 1'b0;
            push_entry.r0 = mk_byte(CH_SPACE);
            has_any       = 1'b1;
        end
        else if (pb_reg)
        begin
            push_entry.r0  = mk_byte(CH_BSLASH);
            push_entry.two = scan_has;
            has_any        = 1'b1;
        end
        else
        begin
            has_any = scan_has;
        end
    end

    assign push = accept && has_any;

endmodule

// ----- rtl/argsp_queue.sv -----
// short queue of classified entries between front and back
// depends on argsp_pkg
module argsp_queue
    import argsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     q_ready,
    input  logic     pop,
    output q_head_t  head
);

    q_entry_t         mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    // pointer advance with wrap
    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_ready    = (count_reg != QCW'(QDEPTH));
    assign head.avail = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- rtl/argsp_back.sv -----
// back part: hands out the one or two results of each queue entry
// depends on argsp_pkg
module argsp_back
    import argsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_head_t    head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       arg_end,
    output logic       end_kind,
    output logic       last
);

    logic    sub_reg, sub_next;
    result_t cur;
    logic    take;

    assign out_valid  = head.avail;
    assign cur        = sub_reg ? head.entry.r1 : head.entry.r0;
    assign out_byte   = cur.out_byte;
    assign byte_valid = cur.byte_valid;
    assign arg_end    = cur.arg_end;
    assign end_kind   = cur.end_kind;
    assign last       = !head.entry.two || sub_reg;
    assign take       = out_valid && out_ready;
    assign pop        = take && last;

    // second result selector
    always_comb
    begin
        sub_next = sub_reg;
        if (take)
            sub_next = !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 1'b0;
        else
            sub_reg <= sub_next;
    end

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for macro_argument_splitter_core
// needs argsp_pkg, argsp_if and the core rtl; predicts every result item and
// checks it against the block under random handshake gaps on both channels
module tb;
    import argsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 850;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 150;

    // tracks the scanner state and holds the result items still owed by the block
    class arg_scan_tracker;
        typedef struct packed {
            result_t r;
            logic    is_last;
        } owed_result_t;

        scan_state_t    st;
        int unsigned    depth;
        bit             held_bslash;
        int unsigned    depth_max;
        result_t        step_out[$];
        owed_result_t   owed[$];
        int             mismatches;

        function new(int unsigned md);
            depth_max = md;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            st = ST_NORMAL;
            depth = 0;
            held_bslash = 1'b0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void char_out(logic [7:0] b);
            result_t r;
            r.out_byte   = b;
            r.byte_valid = 1'b1;
            r.arg_end    = 1'b0;
            r.end_kind   = 1'b0;
            step_out.push_back(r);
        endfunction

        // byte seen as plain code: terminators, parens, literal and comment openers
        function void code_char(logic [7:0] b);
            result_t r;
            if (depth == 0 && (b == CH_RPAR || b == CH_COMMA)) begin
                restart();
                r.out_byte   = 8'h00;
                r.byte_valid = 1'b0;
                r.arg_end    = 1'b1;
                r.end_kind   = (b == CH_RPAR) ? END_RPAR : END_COMMA;
                step_out.push_back(r);
                return;
            end
            if (b == CH_LPAR) begin
                if (depth < depth_max)
                    depth++;
            end else if (b == CH_RPAR) begin
                depth--;
            end else if (b == CH_DQUOTE) begin
                st = ST_STR;
            end else if (b == CH_SQUOTE) begin
                st = ST_CHR;
            end else if (b == CH_SLASH) begin
                st = ST_SLASH;
            end
            char_out(b);
        endfunction

        // one byte through the scanner state machine
        function void scan_char(logic [7:0] b);
            case (st)
                ST_NORMAL:
                begin
                    code_char(b);
                    return;
                end
                ST_SLASH:
                begin
                    if (b == CH_STAR) begin
                        st = ST_BLOCK;
                    end else if (b == CH_SLASH) begin
                        st = ST_LINE;
                    end else begin
                        st = ST_NORMAL;
                        code_char(b);
                        return;
                    end
                end
                ST_BLOCK:
                begin
                    if (b == CH_BSLASH) begin
                        held_bslash = 1'b1;
                        return;
                    end
                    if (b == CH_STAR)
                        st = ST_BLOCK_STAR;
                end
                ST_BLOCK_STAR:
                begin
                    if (b == CH_BSLASH) begin
                        st = ST_BLOCK;
                        held_bslash = 1'b1;
                        return;
                    end
                    if (b == CH_SLASH)
                        st = ST_NORMAL;
                    else if (b != CH_STAR)
                        st = ST_BLOCK;
                end
                ST_LINE:
                begin
                    if (b == CH_BSLASH) begin
                        held_bslash = 1'b1;
                        return;
                    end
                    if (b == CH_NL)
                        st = ST_NORMAL;
                end
                ST_STR:
                begin
                    if (b == CH_DQUOTE)
                        st = ST_NORMAL;
                    else if (b == CH_BSLASH)
                        st = ST_STR_ESC;
                end
                ST_STR_ESC:
                begin
                    st = ST_STR;
                end
                ST_CHR:
                begin
                    if (b == CH_NL || b == CH_SQUOTE)
                        st = ST_NORMAL;
                    else if (b == CH_BSLASH)
                        st = ST_CHR_ESC;
                end
                ST_CHR_ESC:
                begin
                    st = ST_CHR;
                end
                default:
                begin
                    st = ST_NORMAL;
                    code_char(b);
                    return;
                end
            endcase
            char_out(b);
        endfunction

        // accepted input item: work out its results and queue them
        function void note_input(logic [7:0] b, logic m);
            step_out.delete();
            if (m) begin
                if (held_bslash)
                    char_out(CH_BSLASH);
                restart();
            end else if (held_bslash) begin
                held_bslash = 1'b0;
                if (b == CH_NL) begin
                    char_out(CH_SPACE);
                end else begin
                    char_out(CH_BSLASH);
                    scan_char(b);
                end
            end else begin
                scan_char(b);
            end
            foreach (step_out[i])
                owed.push_back(owed_result_t'{r: step_out[i],
                                              is_last: (i == step_out.size() - 1)});
        endfunction

        // accepted result item against the oldest owed one
        function void check_result(result_t act, logic act_last);
            owed_result_t e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result byte %02h valid %b end %b %s",
                             $realtime, act.out_byte, act.byte_valid, act.arg_end,
                             $sformatf("kind %b last %b", act.end_kind, act_last));
                return;
            end
            e = owed.pop_front();
            if (act.out_byte !== e.r.out_byte || act.byte_valid !== e.r.byte_valid ||
                act.arg_end !== e.r.arg_end || act.end_kind !== e.r.end_kind ||
                act_last !== e.is_last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp byte %02h valid %b end %b kind %b last %b,",
                             $realtime, e.r.out_byte, e.r.byte_valid, e.r.arg_end,
                             e.r.end_kind, e.is_last);
                    $display("    got byte %02h valid %b end %b kind %b last %b",
                             act.out_byte, act.byte_valid, act.arg_end,
                             act.end_kind, act_last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    argsp_in_if  in_ch();
    argsp_out_if out_ch();

    macro_argument_splitter_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    arg_scan_tracker arg_track;
    int  n_items;
    int  n_results = 0;
    int  cycle_cnt;
    bit  no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // cycle counter and run limit
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
        end
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // input gap length: mostly none, some short, a few long
    function automatic int sender_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one item from a falling edge and wait for its acceptance
    task automatic send_item(input logic [7:0] b, input logic m);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.mode    <= m;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        arg_track.note_input(b, m);
        n_items++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_flush();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    // short run of ordinary code characters
    task automatic gen_code();
        string alpha;
        int n;
        alpha = "abcxyz019 +-_(()";
        n = $urandom_range(1, 6);
        repeat (n)
            send_char(alpha[$urandom_range(0, alpha.len() - 1)]);
    endtask

    // string literal with escapes
    task automatic gen_string();
        int n;
        n = $urandom_range(0, 6);
        send_char(CH_DQUOTE);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0) begin
                send_char(CH_BSLASH);
                send_char(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 4) == 0) begin
                send_char($urandom_range(0, 1) ? CH_COMMA : CH_RPAR);
            end else begin
                send_char(printable());
            end
        end
        send_char(CH_DQUOTE);
    endtask

    // character literal, closed by a quote or cut by a newline
    task automatic gen_char_lit();
        send_char(CH_SQUOTE);
        if ($urandom_range(0, 2) == 0) begin
            send_char(CH_BSLASH);
            send_char(8'($urandom_range(0, 255)));
        end else begin
            send_char(printable());
        end
        send_char($urandom_range(0, 9) < 7 ? CH_SQUOTE : CH_NL);
    endtask

    // body of a comment: stars, backslash pairs, terminators, newlines
    task automatic gen_comment_body(input bit in_line);
        int n;
        int sel;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: send_char(CH_STAR);
                1:
                begin
                    send_char(CH_BSLASH);
                    send_char(CH_NL);
                end
                2:
                begin
                    send_char(CH_BSLASH);
                    send_char(8'($urandom_range(0, 255)));
                end
                3: send_char($urandom_range(0, 1) ? CH_COMMA : CH_RPAR);
                4: send_char(printable());
                default:
                begin
                    if (!in_line)
                        send_char(CH_NL);
                    else
                        send_char(CH_LPAR);
                end
            endcase
        end
    endtask

    task automatic gen_block_comment();
        send_char(CH_SLASH);
        send_char(CH_STAR);
        gen_comment_body(1'b0);
        if ($urandom_range(0, 9) != 0) begin
            send_char(CH_STAR);
            send_char(CH_SLASH);
        end else begin
            send_char(CH_BSLASH);
            send_flush();
        end
    endtask

    task automatic gen_line_comment();
        send_char(CH_SLASH);
        send_char(CH_SLASH);
        gen_comment_body(1'b1);
        if ($urandom_range(0, 9) < 8) begin
            send_char(CH_NL);
        end else begin
            send_char(CH_BSLASH);
            send_flush();
        end
    endtask

    // close open parens, then end the argument; flush instead inside a literal or comment or deeper than 8
    task automatic gen_terminator();
        int open;
        open = arg_track.depth;
        if (arg_track.st != ST_NORMAL || open > 8) begin
            send_flush();
        end else begin
            repeat (open) send_char(CH_RPAR);
            send_char($urandom_range(0, 1) ? CH_COMMA : CH_RPAR);
        end
    endtask

    task automatic gen_noise();
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    endtask

    // stimulus
    initial
    begin
        int sel;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.mode = 1'b0;
        no_idle = 1'b0;
        n_items = 0;
        arg_track = new(MAX_DEPTH_DEF);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // terminators inside and outside parens
        send_char(CH_LPAR);
        send_char(CH_COMMA);
        send_char(CH_RPAR);
        send_char(CH_COMMA);
        send_char(CH_RPAR);
        // string holding an escaped quote and a comma
        send_char(CH_DQUOTE);
        send_char(CH_BSLASH);
        send_char(CH_DQUOTE);
        send_char(CH_COMMA);
        send_char(CH_DQUOTE);
        // character literal cut by newline
        send_char(CH_SQUOTE);
        send_char(8'hFF);
        send_char(CH_NL);
        // lone slash, then a comma that ends the argument
        send_char(CH_SLASH);
        send_char(CH_COMMA);
        // block comment: backslash-newline, backslash-other, flushed backslash
        send_char(CH_SLASH);
        send_char(CH_STAR);
        send_char(CH_BSLASH);
        send_char(CH_NL);
        send_char(CH_BSLASH);
        send_char(8'h00);
        send_char(CH_STAR);
        send_char(CH_BSLASH);
        send_flush();
        send_flush();

        // depth saturation, decrement from the ceiling, then flush
        repeat (MAX_DEPTH_DEF + 3) send_char(CH_LPAR);
        send_char(CH_RPAR);
        send_char(CH_RPAR);
        send_flush();

        // random well-formed sequences with some noise
        while (n_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                no_idle = !no_idle;
            sel = $urandom_range(0, 99);
            if (sel < 25)
                gen_code();
            else if (sel < 35)
                gen_string();
            else if (sel < 43)
                gen_char_lit();
            else if (sel < 55)
                gen_block_comment();
            else if (sel < 65)
                gen_line_comment();
            else if (sel < 77)
                gen_terminator();
            else if (sel < 82)
            begin
                send_char(CH_SLASH);
                gen_code();
            end
            else if (sel < 86)
                send_flush();
            else
                gen_noise();
        end
        in_ch.valid <= 1'b0;

        // drain and settle
        while (arg_track.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (arg_track.mismatches == 0 && arg_track.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side ready: random stretches, one long hold while input keeps coming
    initial
    begin
        int  run;
        int  r;
        bit  lvl;
        bit  hold_done;
        run = 0;
        lvl = 1'b0;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run == 0) begin
                r = $urandom_range(0, 99);
                if (!hold_done && n_results >= HOLD_AFTER) begin
                    lvl = 1'b0;
                    run = HOLD_CYCLES;
                    hold_done = 1'b1;
                end else if (r < 50) begin
                    lvl = 1'b1;
                    run = $urandom_range(1, 8);
                end else if (r < 60) begin
                    lvl = 1'b1;
                    run = $urandom_range(20, 80);
                end else if (r < 92) begin
                    lvl = 1'b0;
                    run = $urandom_range(1, 3);
                end else if (r < 98) begin
                    lvl = 1'b0;
                    run = $urandom_range(4, 10);
                end else begin
                    lvl = 1'b0;
                    run = $urandom_range(20, 50);
                end
            end
            out_ch.ready <= lvl;
            run--;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t act;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            act.out_byte   = out_ch.out_byte;
            act.byte_valid = out_ch.byte_valid;
            act.arg_end    = out_ch.arg_end;
            act.end_kind   = out_ch.end_kind;
            n_results++;
            arg_track.check_result(act, out_ch.last);
        end
    end

endmodule
